[hw/rtl/bright_run_row_range_detector_assert.svh]
// Assertion macros for the bright run row range detector.
`ifndef BRIGHT_RUN_ROW_RANGE_DETECTOR_ASSERT_SVH
`define BRIGHT_RUN_ROW_RANGE_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on clk and disabled in reset.
`define BRRD_ASSERT_SAME(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked on clk and disabled in reset.
`define BRRD_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`else

`define BRRD_ASSERT_SAME(lbl, pre, post, msg)
`define BRRD_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

[hw/rtl/brrd_pkg.sv]
// Shared types and constants of the bright run row range detector.
`timescale 1ns / 1ps

package brrd_pkg;

    localparam int PIX_W     = 8;
    localparam int CNT_W     = 13;
    localparam int ROW_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;

    // Rows past this count in one frame are ignored.
    localparam int MAX_ROWS = 4096;

    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0] QUIET_MARGIN = 13'd5;

    localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd128;
    localparam logic [CNT_W-1:0] RUN_LEN_RESET   = 13'd32;
    localparam logic [CNT_W-1:0] QUIET_RESET     = 13'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_THRESHOLD = 2'd0,
        CFG_RUN_LENGTH      = 2'd1,
        CFG_QUIET_LIMIT     = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_threshold;
        logic [CNT_W-1:0] run_length;
        logic [CNT_W-1:0] quiet_limit;
    } cfg_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             end_of_row;
        logic             end_of_frame;
    } pixel_word_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_begin;
        logic [CNT_W-1:0] row_end;
        logic             mostly_quiet;
    } result_t;

endpackage

[hw/rtl/brrd_cfg.sv]
// Configuration registers of the bright run row range detector.
`timescale 1ns / 1ps

module brrd_cfg
    import brrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Register select; an index past the list is dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PIXEL_THRESHOLD: cfg_next.pixel_threshold = cfg_data[PIX_W-1:0];
                CFG_RUN_LENGTH:      cfg_next.run_length      = cfg_data[CNT_W-1:0];
                CFG_QUIET_LIMIT:     cfg_next.quiet_limit     = cfg_data[CNT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pixel_threshold <= THRESHOLD_RESET;
            cfg_reg.run_length      <= RUN_LEN_RESET;
            cfg_reg.quiet_limit     <= QUIET_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[hw/rtl/brrd_in_stage.sv]
// Input register stage that holds one pixel word ahead of the row logic.
`timescale 1ns / 1ps

module brrd_in_stage
    import brrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        up_valid,
    output logic        up_ready,
    input  pixel_word_t up_word,
    output logic        dn_valid,
    input  logic        dn_ready,
    output pixel_word_t dn_word
);

    logic        valid_reg;
    logic        valid_next;
    pixel_word_t word_reg;

    // A new word enters when the stage is empty or its word moves on now.
    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

    always_comb
    begin
        if (up_valid && up_ready)
            valid_next = 1'b1;
        else if (dn_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
            word_reg <= up_word;
    end

endmodule

[hw/rtl/brrd_core.sv]
// Run counting, row classification and frame result of the detector.
`timescale 1ns / 1ps

module brrd_core
    import brrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        item_valid,
    input  pixel_word_t item,
    output logic        result_valid,
    output result_t     result
);

    logic [CNT_W-1:0] run_count_reg,       run_count_next;
    logic             run_frozen_reg,      run_frozen_next;
    logic [CNT_W-1:0] row_index_reg,       row_index_next;
    logic [CNT_W-1:0] quiet_rows_reg,      quiet_rows_next;
    logic [ROW_W-1:0] first_hit_row_reg,   first_hit_row_next;
    logic             first_hit_valid_reg, first_hit_valid_next;
    logic [ROW_W-1:0] last_hit_row_reg,    last_hit_row_next;
    logic             last_hit_valid_reg,  last_hit_valid_next;

    logic [CNT_W-1:0] cnt_upd;
    logic             frozen_upd;
    logic             row_done;
    logic             row_take;
    logic             row_hit;
    logic             row_quiet;
    logic [CNT_W-1:0] row_index_upd;
    logic [CNT_W-1:0] quiet_upd;
    logic [ROW_W-1:0] first_row_upd;
    logic             first_valid_upd;
    logic [ROW_W-1:0] last_row_upd;
    logic             last_valid_upd;
    logic             frame_quiet;

    // Run counter: saturating count of bright pixels, frozen once past the run length.
    always_comb
    begin
        cnt_upd    = run_count_reg;
        frozen_upd = run_frozen_reg;
        if (!run_frozen_reg)
        begin
            if (item.pixel > cfg.pixel_threshold)
            begin
                if (run_count_reg != CNT_MAX)
                    cnt_upd = run_count_reg + 13'd1;
            end
            else
            begin
                cnt_upd = '0;
            end
            frozen_upd = (cnt_upd > cfg.run_length);
        end
    end

    // Row end: classify the row value and track the hit range.
    assign row_done  = item.end_of_row || item.end_of_frame;
    assign row_take  = row_done && (32'(row_index_reg) < MAX_ROWS);
    assign row_hit   = row_take && (cnt_upd >= cfg.run_length);
    assign row_quiet = row_take && (cnt_upd <= cfg.quiet_limit) && (quiet_rows_reg != CNT_MAX);

    always_comb
    begin
        row_index_upd   = row_index_reg;
        quiet_upd       = quiet_rows_reg;
        first_row_upd   = first_hit_row_reg;
        first_valid_upd = first_hit_valid_reg;
        last_row_upd    = last_hit_row_reg;
        last_valid_upd  = last_hit_valid_reg;
        if (row_take)
            row_index_upd = row_index_reg + 13'd1;
        if (row_quiet)
            quiet_upd = quiet_rows_reg + 13'd1;
        if (row_hit && !first_hit_valid_reg)
        begin
            first_row_upd   = row_index_reg[ROW_W-1:0];
            first_valid_upd = 1'b1;
        end
        // Row zero may open the range but never close it.
        if (row_hit && (row_index_reg != '0))
        begin
            last_row_upd   = row_index_reg[ROW_W-1:0];
            last_valid_upd = 1'b1;
        end
    end

    // Frame result, built from the counts that include this word's row.
    assign frame_quiet = (row_index_upd >= QUIET_MARGIN) &&
                         (quiet_upd >= (row_index_upd - QUIET_MARGIN));

    always_comb
    begin
        result_valid        = item_valid && item.end_of_frame;
        result.mostly_quiet = frame_quiet;
        if (frame_quiet)
        begin
            result.row_begin = '0;
            result.row_end   = QUIET_MARGIN;
        end
        else
        begin
            result.row_begin = first_valid_upd ? first_row_upd : '0;
            result.row_end   = last_valid_upd ? {1'b0, last_row_upd} : row_index_upd;
        end
    end

    // State update per accepted word; a frame end clears everything.
    always_comb
    begin
        run_count_next       = run_count_reg;
        run_frozen_next      = run_frozen_reg;
        row_index_next       = row_index_reg;
        quiet_rows_next      = quiet_rows_reg;
        first_hit_row_next   = first_hit_row_reg;
        first_hit_valid_next = first_hit_valid_reg;
        last_hit_row_next    = last_hit_row_reg;
        last_hit_valid_next  = last_hit_valid_reg;
        if (item_valid)
        begin
            if (item.end_of_frame)
            begin
                run_count_next       = '0;
                run_frozen_next      = 1'b0;
                row_index_next       = '0;
                quiet_rows_next      = '0;
                first_hit_row_next   = '0;
                first_hit_valid_next = 1'b0;
                last_hit_row_next    = '0;
                last_hit_valid_next  = 1'b0;
            end
            else if (row_done)
            begin
                run_count_next       = '0;
                run_frozen_next      = 1'b0;
                row_index_next       = row_index_upd;
                quiet_rows_next      = quiet_upd;
                first_hit_row_next   = first_row_upd;
                first_hit_valid_next = first_valid_upd;
                last_hit_row_next    = last_row_upd;
                last_hit_valid_next  = last_valid_upd;
            end
            else
            begin
                run_count_next  = cnt_upd;
                run_frozen_next = frozen_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg       <= '0;
            run_frozen_reg      <= 1'b0;
            row_index_reg       <= '0;
            quiet_rows_reg      <= '0;
            first_hit_row_reg   <= '0;
            first_hit_valid_reg <= 1'b0;
            last_hit_row_reg    <= '0;
            last_hit_valid_reg  <= 1'b0;
        end
        else
        begin
            run_count_reg       <= run_count_next;
            run_frozen_reg      <= run_frozen_next;
            row_index_reg       <= row_index_next;
            quiet_rows_reg      <= quiet_rows_next;
            first_hit_row_reg   <= first_hit_row_next;
            first_hit_valid_reg <= first_hit_valid_next;
            last_hit_row_reg    <= last_hit_row_next;
            last_hit_valid_reg  <= last_hit_valid_next;
        end
    end

endmodule

[hw/rtl/brrd_out_stage.sv]
// Result register that holds one frame result until the receiver takes it.
`timescale 1ns / 1ps

module brrd_out_stage
    import brrd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    output logic    free,
    input  logic    word_valid,
    input  result_t word,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    // The register can take a word when it is empty or being drained now.
    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_comb
    begin
        if (free)
            valid_next = word_valid;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (free && word_valid)
            word_reg <= word;
    end

endmodule

[hw/rtl/bright_run_row_range_detector.sv]
// Top level of the bright run row range detector.
// Pixels enter on the s_axis channel in raster order, one word per pixel:
// tdata carries the grey value, tuser marks the last pixel of a row and
// tlast the last pixel of a frame (which also ends its row).
// One result word per frame leaves on the m_axis channel with the first and
// last hit rows and the mostly-quiet flag.
// A pixel word passes an input register and the run and row logic, and its
// result lands in the output register, from which the frame result is offered.
// The block takes one pixel word per cycle while the result register is free;
// the run counter is registered anew for each pixel, before the next pixel of
// the row is counted.
// When the receiver stalls, the result is held; the input register still takes
// a pixel only if empty, and then s_axis_tready drops until the result goes.
// The cfg channel writes threshold, run length and quiet limit; the user must
// write it only while the block is idle, which the block does not enforce.
// Reset sets the registers to 128, 32 and 100, clears all run and row
// counts and empties both register stages.
`timescale 1ns / 1ps
`include "bright_run_row_range_detector_assert.svh"

module bright_run_row_range_detector
    import brrd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,  // [7:0] pixel
    input  logic                 s_axis_tlast,  // end_of_frame
    input  logic                 s_axis_tuser,  // [0] end_of_row
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,  // [11:0] row_begin, [24:12] row_end, zeros
    output logic                 m_axis_tuser,  // [0] mostly_quiet
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    cfg_t        cfg;
    pixel_word_t in_word;
    pixel_word_t core_item;
    logic        core_valid;
    logic        core_fire;
    logic        out_free;
    logic        result_valid;
    result_t     result;
    result_t     out_word;

    assign in_word.pixel        = s_axis_tdata;
    assign in_word.end_of_row   = s_axis_tuser;
    assign in_word.end_of_frame = s_axis_tlast;

    brrd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    brrd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s_axis_tvalid),
        .up_ready (s_axis_tready),
        .up_word  (in_word),
        .dn_valid (core_valid),
        .dn_ready (out_free),
        .dn_word  (core_item)
    );

    // A held pixel is processed when the result register can take its result.
    assign core_fire = core_valid && out_free;

    brrd_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (core_fire),
        .item         (core_item),
        .result_valid (result_valid),
        .result       (result)
    );

    brrd_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .free       (out_free),
        .word_valid (result_valid),
        .word       (result),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_word   (out_word)
    );

    // Pack the result fields from the lowest bit up.
    assign m_axis_tdata = {7'd0, out_word.row_end, out_word.row_begin};
    assign m_axis_tuser = out_word.mostly_quiet;

    // An empty result register never blocks the pixel stream.
    `BRRD_ASSERT_SAME(a_ready_when_out_empty, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

    // A result only appears after a frame-end pixel was processed.
    `BRRD_ASSERT_SAME(a_result_from_frame_end, $rose(m_axis_tvalid), $past(core_fire && core_item.end_of_frame), "result without frame end")

    // A mostly quiet frame always reports the fixed pair.
    `BRRD_ASSERT_SAME(a_quiet_pair, m_axis_tvalid && m_axis_tuser, (m_axis_tdata[11:0] == 12'd0) && (m_axis_tdata[24:12] == QUIET_MARGIN), "quiet frame with wrong range")

    // A frame-end pixel taken by the core always reaches the result register.
    `BRRD_ASSERT_NEXT(a_frame_end_lands, core_fire && core_item.end_of_frame, m_axis_tvalid, "frame result lost")

endmodule
